/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files of this project.
// Needs no other file; every macro samples on the rising edge of the given clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, disabled while reset is low.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cfd_pkg.sv */
// Package for the CAN receive filter and dispatch block: sizes, item types,
// result codes, controller states and the command and status groups. No dependencies.
`timescale 1ns / 1ps

package cfd_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int ID_BITS     = 29;
	localparam int FLAG_BITS   = 8;
	localparam int TAG_BITS    = 8;
	localparam int SLOT_BITS   = $clog2(MAX_ENTRIES);
	localparam int COUNT_BITS  = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		RES_REG   = 2'd0,
		RES_MATCH = 2'd1,
		RES_SUM   = 2'd2
	} result_type_t;

	localparam logic KIND_REGISTER = 1'b0;
	localparam logic KIND_FRAME    = 1'b1;

	localparam logic STATUS_STORED = 1'b0;
	localparam logic STATUS_FULL   = 1'b1;

	typedef struct packed {
		logic                 kind;
		logic [ID_BITS-1:0]   frame_id;
		logic [FLAG_BITS-1:0] frame_flags;
		logic [ID_BITS-1:0]   entry_filter;
		logic [ID_BITS-1:0]   entry_mask;
		logic [FLAG_BITS-1:0] entry_required;
		logic [TAG_BITS-1:0]  entry_tag;
	} req_item_t;

	typedef struct packed {
		result_type_t          result_type;
		logic                  reg_status;
		logic [SLOT_BITS-1:0]  slot;
		logic [TAG_BITS-1:0]   tag;
		logic [COUNT_BITS-1:0] match_count;
		logic                  last;
	} rsp_item_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_REG  = 2'd1,
		ST_SCAN = 2'd2
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic emit_reg;
		logic emit_match;
		logic emit_sum;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic pend_any;
	} dp_status_t;

endpackage

/* rtl/can_rx_filter_dispatch_core.sv */
// CAN receive acceptance filter bank with dispatch. A register item appends one
// entry (ID filter, ID mask, required flag bits, destination tag) to a table of
// sixteen slots and is answered by one result: stored with its slot, or full.
// A frame item is compared against every stored entry at once; the block then
// reports each matching entry in slot order, one result per cycle while rsp_stall
// is low, then closes with a summary that carries the match count and has last set.
// An entry matches when the frame ID agrees with the filter on every mask bit
// and all required flags are set, so a zero mask accepts any ID. Items are
// taken one at a time: a new one is accepted only when the controller is idle,
// once the last result of the previous item is in the single result register;
// a result held there by rsp_stall delays the next.
// Reset empties the table; the entry contents are not cleared.
// Depends on cfd_pkg, cfd_ctrl and cfd_datapath.
`timescale 1ns / 1ps

module can_rx_filter_dispatch_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  cfd_pkg::req_item_t req_item,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output cfd_pkg::rsp_item_t rsp_item
);

	// Commands from the controller and status back from the datapath.
	cfd_pkg::dp_cmd_t    cmd;
	cfd_pkg::dp_status_t status;

	// The controller accepts an item only when idle and then issues one
	// emit command per cycle whenever the result register can take a result.
	cfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_kind  (req_item.kind),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the table, captures the match vector of a frame as it
	// is accepted, and walks that vector from the lowest slot upward.
	cfd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_item  (req_item),
		.cmd       (cmd),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

endmodule

/* rtl/cfd_datapath.sv */
// Datapath: filter table, parallel match compare, pending-match scan and result register.
// Depends on cfd_pkg.
`timescale 1ns / 1ps

module cfd_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  cfd_pkg::req_item_t req_item,
	input  cfd_pkg::dp_cmd_t   cmd,
	output cfd_pkg::dp_status_t status,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output cfd_pkg::rsp_item_t rsp_item
);

	logic [cfd_pkg::ID_BITS-1:0]    val_q  [cfd_pkg::MAX_ENTRIES];
	logic [cfd_pkg::ID_BITS-1:0]    mask_q [cfd_pkg::MAX_ENTRIES];
	logic [cfd_pkg::FLAG_BITS-1:0]  reqd_q [cfd_pkg::MAX_ENTRIES];
	logic [cfd_pkg::TAG_BITS-1:0]   tag_q  [cfd_pkg::MAX_ENTRIES];
	logic [cfd_pkg::COUNT_BITS-1:0] cnt_q;

	logic [cfd_pkg::ID_BITS-1:0]    ent_filter_q;
	logic [cfd_pkg::ID_BITS-1:0]    ent_mask_q;
	logic [cfd_pkg::FLAG_BITS-1:0]  ent_required_q;
	logic [cfd_pkg::TAG_BITS-1:0]   ent_tag_q;

	logic [cfd_pkg::MAX_ENTRIES-1:0] pend_q;
	logic [cfd_pkg::COUNT_BITS-1:0]  mcount_q;
	logic                            out_valid_q;
	cfd_pkg::rsp_item_t              out_q;

	logic [cfd_pkg::MAX_ENTRIES-1:0] match_vec;
	logic [cfd_pkg::MAX_ENTRIES-1:0] first_hot;
	logic [cfd_pkg::SLOT_BITS-1:0]   first_idx;
	logic                            full;
	logic                            emit_any;

	assign full     = (cnt_q == cfd_pkg::COUNT_BITS'(cfd_pkg::MAX_ENTRIES));
	assign emit_any = cmd.emit_reg | cmd.emit_match | cmd.emit_sum;

	// Every stored entry is compared against the incoming frame at once.
	always_comb begin
		for (int i = 0; i < cfd_pkg::MAX_ENTRIES; i++) begin
			match_vec[i] = (cfd_pkg::COUNT_BITS'(i) < cnt_q)
				&& (((req_item.frame_id ^ val_q[i]) & mask_q[i]) == '0)
				&& ((req_item.frame_flags & reqd_q[i]) == reqd_q[i]);
		end
	end

	// Lowest pending slot, isolated as a one-hot word and then encoded.
	assign first_hot = pend_q & (~pend_q + cfd_pkg::MAX_ENTRIES'(1));

	always_comb begin
		first_idx = '0;
		for (int i = 0; i < cfd_pkg::MAX_ENTRIES; i++) begin
			first_idx = first_idx | (first_hot[i] ? cfd_pkg::SLOT_BITS'(i) : '0);
		end
	end

	assign status.out_free = !out_valid_q || !rsp_stall;
	assign status.pend_any = |pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pend_q      <= '0;
			mcount_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				pend_q   <= match_vec;
				mcount_q <= '0;
			end
			if (cmd.emit_reg && !full) begin
				cnt_q <= cnt_q + cfd_pkg::COUNT_BITS'(1);
			end
			if (cmd.emit_match) begin
				pend_q   <= pend_q & ~first_hot;
				mcount_q <= mcount_q + cfd_pkg::COUNT_BITS'(1);
			end
			if (emit_any) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ent_filter_q   <= req_item.entry_filter;
			ent_mask_q     <= req_item.entry_mask;
			ent_required_q <= req_item.entry_required;
			ent_tag_q      <= req_item.entry_tag;
		end
		if (cmd.emit_reg && !full) begin
			val_q[cnt_q[cfd_pkg::SLOT_BITS-1:0]]  <= ent_filter_q;
			mask_q[cnt_q[cfd_pkg::SLOT_BITS-1:0]] <= ent_mask_q;
			reqd_q[cnt_q[cfd_pkg::SLOT_BITS-1:0]] <= ent_required_q;
			tag_q[cnt_q[cfd_pkg::SLOT_BITS-1:0]]  <= ent_tag_q;
		end
		if (cmd.emit_reg) begin
			out_q.result_type <= cfd_pkg::RES_REG;
			out_q.reg_status  <= full ? cfd_pkg::STATUS_FULL : cfd_pkg::STATUS_STORED;
			out_q.slot        <= full ? '0 : cnt_q[cfd_pkg::SLOT_BITS-1:0];
			out_q.tag         <= '0;
			out_q.match_count <= '0;
			out_q.last        <= 1'b1;
		end else if (cmd.emit_match) begin
			out_q.result_type <= cfd_pkg::RES_MATCH;
			out_q.reg_status  <= cfd_pkg::STATUS_STORED;
			out_q.slot        <= first_idx;
			out_q.tag         <= tag_q[first_idx];
			out_q.match_count <= '0;
			out_q.last        <= 1'b0;
		end else if (cmd.emit_sum) begin
			out_q.result_type <= cfd_pkg::RES_SUM;
			out_q.reg_status  <= cfd_pkg::STATUS_STORED;
			out_q.slot        <= '0;
			out_q.tag         <= '0;
			out_q.match_count <= mcount_q;
			out_q.last        <= 1'b1;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_item  = out_q;

endmodule

/* rtl/cfd_ctrl.sv */
// Controller state machine: takes items, then steps the datapath through its results.
// Depends on cfd_pkg.
`timescale 1ns / 1ps

module cfd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_kind,
	output logic                req_stall,
	input  cfd_pkg::dp_status_t status,
	output cfd_pkg::dp_cmd_t    cmd
);

	cfd_pkg::ctrl_state_t state_q;
	cfd_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			cfd_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d = (req_kind == cfd_pkg::KIND_FRAME) ? cfd_pkg::ST_SCAN
						: cfd_pkg::ST_REG;
				end
			end
			cfd_pkg::ST_REG: begin
				if (status.out_free) begin
					cmd.emit_reg = 1'b1;
					state_d = cfd_pkg::ST_IDLE;
				end
			end
			cfd_pkg::ST_SCAN: begin
				if (status.out_free) begin
					if (status.pend_any) begin
						cmd.emit_match = 1'b1;
					end else begin
						cmd.emit_sum = 1'b1;
						state_d = cfd_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = cfd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/cfd_checker.sv */
// Port-level checker for the CAN filter dispatch block, bound to the top level.
// Depends on cfd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input cfd_pkg::req_item_t req_item,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input cfd_pkg::rsp_item_t rsp_item
);

	logic req_take;
	logic rsp_hold;
	logic take_ok;
	logic sum_out;
	logic count_ok;

	assign req_take = req_valid && !req_stall;
	assign rsp_hold = rsp_valid && rsp_stall;
	assign take_ok  = !rsp_valid || rsp_item.last;
	assign sum_out  = rsp_valid && (rsp_item.result_type == cfd_pkg::RES_SUM);
	assign count_ok = rsp_item.match_count <= cfd_pkg::COUNT_BITS'(cfd_pkg::MAX_ENTRIES);

	// A held result stays on offer.
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_hold, rsp_valid, "result dropped while stalled")

	// The block works on one item at a time.
	`ASSERT_NEXT(a_busy_after_take, clk, arst_n, req_take, req_stall, "new item taken while busy")

	// A new item is taken only once the previous item's final result is out.
	`ASSERT_SAME(a_take_after_last, clk, arst_n, req_take, take_ok, "item taken before last")

	// A summary never counts more matches than the table holds.
	`ASSERT_SAME(a_sum_count, clk, arst_n, sum_out, count_ok, "match count too large")

endmodule

bind can_rx_filter_dispatch_core cfd_checker u_cfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_item  (req_item),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_item  (rsp_item)
);

/* dv/can_rx_filter_dispatch_core_tb.sv */
// Self-checking testbench for can_rx_filter_dispatch_core: directed and random
// filter registrations and frame dispatches, checked against a built-in model.
// Depends on cfd_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module can_rx_filter_dispatch_core_tb;

	import cfd_pkg::*;

	// Clock, reset and the two channels of the block.
	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req_item  = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp_item;

	can_rx_filter_dispatch_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	// 10 ns period: high half, then low half.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Our own copy of the filter table. It is updated when an item is
	// accepted, so it always reflects what the block has been told so far.
	logic [ID_BITS-1:0]   bank_filter [MAX_ENTRIES];
	logic [ID_BITS-1:0]   bank_mask   [MAX_ENTRIES];
	logic [FLAG_BITS-1:0] bank_needed [MAX_ENTRIES];
	logic [TAG_BITS-1:0]  bank_tag    [MAX_ENTRIES];
	int                   bank_count = 0;

	// Answers the block still owes us, oldest first.
	rsp_item_t pending_answers [$];
	int        mismatch_count = 0;

	// Idling controls. The sender inserts gaps between items, the receiver
	// stalls in bursts, and a long hold can be requested from the receiver.
	bit req_gaps_on   = 1'b0;
	bit rsp_stalls_on = 1'b0;
	int hold_cycles   = 0;

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Works out every answer that one accepted item causes and queues them.
	// A registration appends to the table or reports it full; a frame yields
	// one answer per matching slot in slot order and then the summary.
	function automatic void apply_to_filter_bank(input req_item_t it);
		rsp_item_t ans;
		int        hits;
		hits = 0;
		if (it.kind == KIND_REGISTER) begin
			ans             = '0;
			ans.result_type = RES_REG;
			ans.last        = 1'b1;
			if (bank_count >= MAX_ENTRIES) begin
				// Nothing is stored and the slot stays zero.
				ans.reg_status = STATUS_FULL;
			end else begin
				bank_filter[bank_count] = it.entry_filter;
				bank_mask[bank_count]   = it.entry_mask;
				bank_needed[bank_count] = it.entry_required;
				bank_tag[bank_count]    = it.entry_tag;
				ans.reg_status          = STATUS_STORED;
				ans.slot                = SLOT_BITS'(bank_count);
				bank_count++;
			end
			pending_answers.push_back(ans);
		end else begin
			// Only slots below the fill level are looked at, so unwritten
			// entries never take part in a match.
			for (int i = 0; i < bank_count; i++) begin
				if (((it.frame_id & bank_mask[i]) == (bank_filter[i] & bank_mask[i])) &&
						((it.frame_flags & bank_needed[i]) == bank_needed[i])) begin
					ans             = '0;
					ans.result_type = RES_MATCH;
					ans.slot        = SLOT_BITS'(i);
					ans.tag         = bank_tag[i];
					pending_answers.push_back(ans);
					hits++;
				end
			end
			ans             = '0;
			ans.result_type = RES_SUM;
			ans.match_count = COUNT_BITS'(hits);
			ans.last        = 1'b1;
			pending_answers.push_back(ans);
		end
	endfunction

	// Each answer taken from the block is compared with the oldest one owed.
	task automatic check_answer(input rsp_item_t got);
		rsp_item_t want;
		if (pending_answers.size() == 0) begin
			report_mismatch("answer with none outstanding, type", got.result_type, 0);
		end else begin
			want = pending_answers.pop_front();
			if (got.result_type != want.result_type)
				report_mismatch("result_type", got.result_type, want.result_type);
			if (got.reg_status != want.reg_status)
				report_mismatch("reg_status", got.reg_status, want.reg_status);
			if (got.slot != want.slot)
				report_mismatch("slot", got.slot, want.slot);
			if (got.tag != want.tag)
				report_mismatch("tag", got.tag, want.tag);
			if (got.match_count != want.match_count)
				report_mismatch("match_count", got.match_count, want.match_count);
			if (got.last != want.last)
				report_mismatch("last", got.last, want.last);
		end
	endtask

	// Answers are taken at the rising edge where valid is high and our stall
	// is low; the stall was set at the previous falling edge, so it is stable.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			check_answer(rsp_item);
		end
	end

	// Receiver: a requested hold wins, otherwise random stall bursts when
	// enabled, otherwise it takes everything offered.
	always begin
		@(negedge clk);
		if (hold_cycles > 0) begin
			rsp_stall = 1'b1;
			for (int held = 1; held < hold_cycles; held++) begin
				@(negedge clk);
			end
			hold_cycles = 0;
		end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
			rsp_stall = 1'b1;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end else begin
			rsp_stall = 1'b0;
		end
	end

	// Offers one item and returns at the edge that accepts it. Valid is left
	// high, so a following call presents the next item without a bubble; any
	// wait that is not another send must lower valid first.
	task automatic send_item(input req_item_t it);
		@(negedge clk);
		if (req_gaps_on && $urandom_range(0, 3) == 0) begin
			req_valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		req_valid = 1'b1;
		req_item  = it;
		do @(posedge clk); while (req_stall);
		apply_to_filter_bank(it);
	endtask

	// Stops offering and waits until every answer owed has been taken.
	task automatic wait_all_answered();
		@(negedge clk);
		req_valid = 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
	endtask

	// An item with every field random; the block must ignore the fields that
	// do not belong to its kind.
	function automatic req_item_t noise_item();
		req_item_t it;
		it.kind           = 1'($urandom_range(0, 1));
		it.frame_id       = ID_BITS'($urandom());
		it.frame_flags    = FLAG_BITS'($urandom());
		it.entry_filter   = ID_BITS'($urandom());
		it.entry_mask     = ID_BITS'($urandom());
		it.entry_required = FLAG_BITS'($urandom());
		it.entry_tag      = TAG_BITS'($urandom());
		return it;
	endfunction

	// A registration whose mask and flag requirement lean toward the cases
	// that matter: accept-all masks, exact masks, sparse masks and flags.
	function automatic req_item_t random_entry();
		req_item_t it;
		it      = noise_item();
		it.kind = KIND_REGISTER;
		case ($urandom_range(0, 9))
			0, 1: begin
				it.entry_mask = '0;
			end
			2, 3: begin
				it.entry_mask = '1;
			end
			4, 5, 6: begin
				it.entry_mask = ID_BITS'($urandom());
			end
			default: begin
				it.entry_mask = ID_BITS'($urandom() & $urandom() & $urandom());
			end
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				it.entry_required = '0;
			end
			4, 5, 6, 7: begin
				it.entry_required = FLAG_BITS'($urandom() & $urandom());
			end
			8: begin
				it.entry_required = '1;
			end
			default: begin
			end
		endcase
		return it;
	endfunction

	// A frame aimed at one stored slot: the masked ID bits agree and the
	// required flags are present. Now and then one ID bit or one flag bit is
	// flipped so that near misses are exercised as well.
	function automatic req_item_t frame_for_slot(input int s);
		req_item_t it;
		it             = noise_item();
		it.kind        = KIND_FRAME;
		it.frame_id    = (bank_filter[s] & bank_mask[s]) |
			(ID_BITS'($urandom()) & ~bank_mask[s]);
		it.frame_flags = bank_needed[s] | FLAG_BITS'($urandom());
		if ($urandom_range(0, 5) == 0)
			it.frame_id[$urandom_range(0, ID_BITS - 1)] ^= 1'b1;
		if ($urandom_range(0, 7) == 0)
			it.frame_flags[$urandom_range(0, FLAG_BITS - 1)] ^= 1'b1;
		return it;
	endfunction

	// Mostly well-aimed frames, with plain noise frames and frames at the ID
	// extremes mixed in.
	function automatic req_item_t random_frame();
		req_item_t it;
		int        pick;
		pick = $urandom_range(0, 19);
		if (bank_count > 0 && pick < 15) begin
			it = frame_for_slot($urandom_range(0, bank_count - 1));
		end else begin
			it      = noise_item();
			it.kind = KIND_FRAME;
			if (pick == 19)
				it.frame_id = '1;
			else if (pick == 18)
				it.frame_id = '0;
		end
		return it;
	endfunction

	// A frame on an empty table yields only the summary with a zero count.
	task automatic test_empty_table();
		req_item_t it;
		it      = '0;
		it.kind = KIND_FRAME;
		it.entry_filter   = '1;
		it.entry_mask     = '1;
		it.entry_required = '1;
		it.entry_tag      = '1;
		send_item(it);
		it             = '0;
		it.kind        = KIND_FRAME;
		it.frame_id    = '1;
		it.frame_flags = '1;
		send_item(it);
		wait_all_answered();
	endtask

	// Four entries at the corners: accept-all, exact all-ones with every flag
	// required, exact zero, and an alternating pattern under a partial mask.
	task automatic test_register_corners();
		req_item_t it;
		it                = '0;
		it.kind           = KIND_REGISTER;
		it.frame_id       = '1;
		it.frame_flags    = '1;
		it.entry_filter   = '1;
		send_item(it);
		it                = '0;
		it.kind           = KIND_REGISTER;
		it.entry_filter   = '1;
		it.entry_mask     = '1;
		it.entry_required = '1;
		it.entry_tag      = '1;
		send_item(it);
		it                = '0;
		it.kind           = KIND_REGISTER;
		it.entry_mask     = '1;
		it.entry_tag      = 8'h55;
		send_item(it);
		it                = '0;
		it.kind           = KIND_REGISTER;
		it.entry_filter   = 29'h0AAA_AAAA;
		it.entry_mask     = 29'h1555_5555;
		it.entry_required = 8'h01;
		it.entry_tag      = 8'hAA;
		send_item(it);
		wait_all_answered();
	endtask

	// Frames that hit the corner entries in different combinations, including
	// one that misses only for want of a single flag bit.
	task automatic test_frame_matching();
		req_item_t it;
		it             = '0;
		it.kind        = KIND_FRAME;
		it.frame_id    = '1;
		it.frame_flags = '1;
		send_item(it);
		it.frame_flags = 8'hFE;
		send_item(it);
		it.frame_id    = '0;
		it.frame_flags = '0;
		it.entry_filter   = '1;
		it.entry_mask     = '1;
		it.entry_required = '1;
		it.entry_tag      = '1;
		send_item(it);
		it             = '0;
		it.kind        = KIND_FRAME;
		it.frame_id    = 29'h0AAA_AAAA;
		it.frame_flags = 8'h01;
		send_item(it);
		it.frame_id    = 29'h1555_5555;
		it.frame_flags = 8'h80;
		send_item(it);
		wait_all_answered();
	endtask

	// Random registrations mixed with frames until the table is full, then
	// registrations that must be refused, the first one with extreme fields.
	task automatic test_fill_to_full();
		req_item_t it;
		req_gaps_on   = 1'b1;
		rsp_stalls_on = 1'b1;
		while (bank_count < MAX_ENTRIES) begin
			if ($urandom_range(0, 2) == 0)
				send_item(random_entry());
			else
				send_item(random_frame());
		end
		it                = '1;
		it.kind           = KIND_REGISTER;
		send_item(it);
		repeat (3) send_item(random_entry());
	endtask

	// The bulk of the run on a full table. Halfway through the sender stops
	// until every answer owed has come back.
	task automatic test_random_traffic(input int count);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				wait_all_answered();
			if ($urandom_range(0, 9) == 0)
				send_item(random_entry());
			else
				send_item(random_frame());
		end
		wait_all_answered();
	endtask

	// The receiver holds off for a long stretch while the sender keeps going,
	// so the block backs up and stalls its input.
	task automatic test_backpressure();
		req_gaps_on = 1'b0;
		hold_cycles = 300;
		repeat (30) send_item(random_frame());
		wait_all_answered();
		req_gaps_on = 1'b1;
	endtask

	// Closing stretch with no idling on either side, at full rate.
	task automatic test_full_rate_tail();
		req_gaps_on   = 1'b0;
		rsp_stalls_on = 1'b0;
		repeat (50) begin
			if ($urandom_range(0, 9) == 0)
				send_item(random_entry());
			else
				send_item(random_frame());
		end
		wait_all_answered();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_register_corners();
		test_frame_matching();
		test_fill_to_full();
		test_random_traffic(200);
		test_backpressure();
		test_full_rate_tail();

		// Let the clock run on so that any answer nobody asked for shows up.
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Far beyond the slowest correct run: every item at its most answers,
	// each answer stalled to the longest burst, plus sender gaps and the hold.
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
